// ===== design/aabb_triangle_overlap_test_core_macros.svh =====
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_test_core_macros
// Assertion macros shared by the overlap test core.
// ----------------------------------------------------------------------------
`ifndef AABB_TRIANGLE_OVERLAP_TEST_CORE_MACROS_SVH
`define AABB_TRIANGLE_OVERLAP_TEST_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ATOT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atot assertion failed");

// Next-cycle implication, checked out of reset.
`define ATOT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atot assertion failed");

`endif

// ===== design/atot_pkg.sv =====
// ----------------------------------------------------------------------------
// atot_pkg
// Shared constants and register codes of the box / triangle overlap core.
// ----------------------------------------------------------------------------
`default_nettype none
package atot_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int NORM_EPS_RAW   = 16;
   localparam int CSR_IDX_BITS   = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } atot_reg_type;
endpackage
`default_nettype wire

// ===== design/atot_if.sv =====
// ----------------------------------------------------------------------------
// atot channel interfaces
// Triangle request, overlap response and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface atot_req_if #(parameter int W = atot_pkg::COORD_BITS_DEF) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] v0_x, v0_y, v0_z;
   logic signed [W-1:0] v1_x, v1_y, v1_z;
   logic signed [W-1:0] v2_x, v2_y, v2_z;
   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, input ready);
   modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, output ready);
endinterface

interface atot_rsp_if ();
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

interface atot_csr_if #(parameter int W = atot_pkg::COORD_BITS_DEF) ();
   logic                                valid;
   logic                                ready;
   logic [atot_pkg::CSR_IDX_BITS-1:0]   index;
   logic [W-1:0]                        data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/aabb_triangle_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_test_core
// Separating axis overlap test of one triangle per beat against a fixed box.
// ----------------------------------------------------------------------------
// The box corners sit in six registers written over the csr channel. Each
// request beat carries one triangle; each response beat carries one hit flag
// (1 when none of the 13 axes separates box and triangle). All math is exact.
// A triangle goes from request to response through a six-register pipeline
// (differences, edge and normal products, edge sums, split normal products,
// partial merge, final sums), and the core takes one triangle every cycle
// while the response side keeps taking beats. A stall on the response side
// halts the whole pipeline; no beat is lost or repeated.
// Registers should be written only while no triangle is in flight.
`default_nettype none
module aabb_triangle_overlap_test_core #(
   parameter int COORD_BITS = atot_pkg::COORD_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   atot_req_if.sink   req_ch,
   atot_rsp_if.source rsp_ch,
   atot_csr_if.sink   csr_ch
);
   import atot_pkg::*;

   `include "aabb_triangle_overlap_test_core_macros.svh"

   localparam int C     = COORD_BITS;
   localparam int DW    = C + 1;
   localparam int PW    = 2 * C + 2;
   localparam int ESW   = PW + 1;
   localparam int NW    = 2 * C + 3;
   localparam int LW    = (NW + 1) / 2;
   localparam int HW    = NW - LW;
   localparam int PLW   = LW + 1 + DW;
   localparam int PHW   = HW + DW;
   localparam int FW    = NW + DW;
   localparam int FSW   = FW + 2;
   localparam int DEPTH = 6;

   // box registers
   logic signed [C-1:0] bmin_ff [3];
   logic signed [C-1:0] bmax_ff [3];

   logic [DEPTH-1:0] vld_ff;
   logic             adv;
   logic             take;

   assign adv          = !vld_ff[DEPTH-1] || rsp_ch.ready;
   assign take         = req_ch.valid && adv;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            bmin_ff[k] <= '0;
            bmax_ff[k] <= '0;
         end
      end else if (csr_ch.valid) begin
         unique case (atot_reg_type'(csr_ch.index))
            REG_BOX_MIN_X: bmin_ff[0] <= $signed(csr_ch.data[C-1:0]);
            REG_BOX_MIN_Y: bmin_ff[1] <= $signed(csr_ch.data[C-1:0]);
            REG_BOX_MIN_Z: bmin_ff[2] <= $signed(csr_ch.data[C-1:0]);
            REG_BOX_MAX_X: bmax_ff[0] <= $signed(csr_ch.data[C-1:0]);
            REG_BOX_MAX_Y: bmax_ff[1] <= $signed(csr_ch.data[C-1:0]);
            REG_BOX_MAX_Z: bmax_ff[2] <= $signed(csr_ch.data[C-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_ch.valid};
      end
   end

   // ---------------- stage 1: differences, unit axes ----------------
   logic signed [DW-1:0] rlo_in [3][3], rhi_in [3][3], eg_in [3][3], wg_in [3][3];
   logic                 unit_in;
   logic signed [DW-1:0] rlo1_ff [3][3], rhi1_ff [3][3], eg_ff [3][3], wg_ff [3][3];
   logic                 unit1_ff;

   always_comb begin
      logic signed [C-1:0] v [3][3];
      logic signed [C-1:0] lo, hi, vmin, vmax;
      v[0][0] = req_ch.v0_x; v[0][1] = req_ch.v0_y; v[0][2] = req_ch.v0_z;
      v[1][0] = req_ch.v1_x; v[1][1] = req_ch.v1_y; v[1][2] = req_ch.v1_z;
      v[2][0] = req_ch.v2_x; v[2][1] = req_ch.v2_y; v[2][2] = req_ch.v2_z;
      unit_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         lo   = (bmin_ff[k] < bmax_ff[k]) ? bmin_ff[k] : bmax_ff[k];
         hi   = (bmin_ff[k] < bmax_ff[k]) ? bmax_ff[k] : bmin_ff[k];
         vmin = (v[0][k] < v[1][k]) ? v[0][k] : v[1][k];
         vmin = (v[2][k] < vmin) ? v[2][k] : vmin;
         vmax = (v[0][k] > v[1][k]) ? v[0][k] : v[1][k];
         vmax = (v[2][k] > vmax) ? v[2][k] : vmax;
         unit_in = unit_in && (lo <= vmax) && (vmin <= hi);
         for (int i = 0; i < 3; i++) begin
            rlo_in[i][k] = DW'(lo) - DW'(v[i][k]);
            rhi_in[i][k] = DW'(hi) - DW'(v[i][k]);
            eg_in[i][k]  = DW'(v[(i+1)%3][k]) - DW'(v[i][k]);
            wg_in[i][k]  = DW'(v[(i+2)%3][k]) - DW'(v[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rlo1_ff  <= rlo_in;
         rhi1_ff  <= rhi_in;
         eg_ff    <= eg_in;
         wg_ff    <= wg_in;
         unit1_ff <= unit_in;
      end
   end

   // ---------------- stage 2: edge axis and normal products ----------------
   logic signed [PW-1:0] elo_in [3][3][2], ehi_in [3][3][2], et_in [3][3][2];
   logic                 ez_in  [3][3];
   logic signed [PW-1:0] np_in [3], nq_in [3];
   logic signed [PW-1:0] elo_ff [3][3][2], ehi_ff [3][3][2], et_ff [3][3][2];
   logic                 ez_ff  [3][3];
   logic signed [PW-1:0] np_ff [3], nq_ff [3];
   logic signed [DW-1:0] rlo2_ff [3], rhi2_ff [3];
   logic                 unit2_ff;

   always_comb begin
      logic signed [DW-1:0] cmp [2];
      int                   ci [2];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            case (j)
               0: begin
                  cmp[0] = eg_ff[i][2];  cmp[1] = -eg_ff[i][1]; ci[0] = 1; ci[1] = 2;
               end
               1: begin
                  cmp[0] = -eg_ff[i][2]; cmp[1] = eg_ff[i][0];  ci[0] = 0; ci[1] = 2;
               end
               default: begin
                  cmp[0] = eg_ff[i][1];  cmp[1] = -eg_ff[i][0]; ci[0] = 0; ci[1] = 1;
               end
            endcase
            ez_in[i][j] = (cmp[0] == '0) && (cmp[1] == '0);
            for (int c = 0; c < 2; c++) begin
               elo_in[i][j][c] = cmp[c] * (cmp[c][DW-1] ? rhi1_ff[i][ci[c]]
                                                        : rlo1_ff[i][ci[c]]);
               ehi_in[i][j][c] = cmp[c] * (cmp[c][DW-1] ? rlo1_ff[i][ci[c]]
                                                        : rhi1_ff[i][ci[c]]);
               et_in[i][j][c]  = cmp[c] * wg_ff[i][ci[c]];
            end
         end
      end
      // normal = (v1 - v0) x (v2 - v0)
      np_in[0] = eg_ff[0][1] * wg_ff[0][2];
      nq_in[0] = eg_ff[0][2] * wg_ff[0][1];
      np_in[1] = eg_ff[0][2] * wg_ff[0][0];
      nq_in[1] = eg_ff[0][0] * wg_ff[0][2];
      np_in[2] = eg_ff[0][0] * wg_ff[0][1];
      nq_in[2] = eg_ff[0][1] * wg_ff[0][0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         elo_ff   <= elo_in;
         ehi_ff   <= ehi_in;
         et_ff    <= et_in;
         ez_ff    <= ez_in;
         np_ff    <= np_in;
         nq_ff    <= nq_in;
         rlo2_ff  <= rlo1_ff[0];
         rhi2_ff  <= rhi1_ff[0];
         unit2_ff <= unit1_ff;
      end
   end

   // ---------------- stage 3: edge axis sums, normal ----------------
   logic                 edge_in;
   logic signed [NW-1:0] n_in [3];
   logic                 edge3_ff, unit3_ff;
   logic signed [NW-1:0] n_ff [3];
   logic signed [DW-1:0] rlo3_ff [3], rhi3_ff [3];

   always_comb begin
      logic signed [ESW-1:0] blo, bhi, t, tmin, tmax;
      edge_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            blo  = ESW'(elo_ff[i][j][0]) + ESW'(elo_ff[i][j][1]);
            bhi  = ESW'(ehi_ff[i][j][0]) + ESW'(ehi_ff[i][j][1]);
            t    = ESW'(et_ff[i][j][0]) + ESW'(et_ff[i][j][1]);
            tmin = t[ESW-1] ? t : '0;
            tmax = t[ESW-1] ? '0 : t;
            edge_in = edge_in && (ez_ff[i][j] || ((blo <= tmax) && (tmin <= bhi)));
         end
      end
      for (int k = 0; k < 3; k++) begin
         n_in[k] = NW'(np_ff[k]) - NW'(nq_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         edge3_ff <= edge_in;
         unit3_ff <= unit2_ff;
         n_ff     <= n_in;
         rlo3_ff  <= rlo2_ff;
         rhi3_ff  <= rhi2_ff;
      end
   end

   // ---------------- stage 4: split normal products ----------------
   logic signed [PLW-1:0] pll_in [3], phl_in [3];
   logic signed [PHW-1:0] plh_in [3], phh_in [3];
   logic                  small_in;
   logic signed [PLW-1:0] pll_ff [3], phl_ff [3];
   logic signed [PHW-1:0] plh_ff [3], phh_ff [3];
   logic                  small4_ff, edge4_ff, unit4_ff;

   always_comb begin
      logic signed [DW-1:0] dl, dh;
      logic signed [LW:0]   nl;
      logic signed [HW-1:0] nh;
      small_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         small_in = small_in && (n_ff[k] >= -NW'(NORM_EPS_RAW))
                             && (n_ff[k] <= NW'(NORM_EPS_RAW));
         dl = n_ff[k][NW-1] ? rhi3_ff[k] : rlo3_ff[k];
         dh = n_ff[k][NW-1] ? rlo3_ff[k] : rhi3_ff[k];
         nl = $signed({1'b0, n_ff[k][LW-1:0]});
         nh = n_ff[k][NW-1:LW];
         pll_in[k] = nl * dl;
         plh_in[k] = nh * dl;
         phl_in[k] = nl * dh;
         phh_in[k] = nh * dh;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff    <= pll_in;
         plh_ff    <= plh_in;
         phl_ff    <= phl_in;
         phh_ff    <= phh_in;
         small4_ff <= small_in;
         edge4_ff  <= edge3_ff;
         unit4_ff  <= unit3_ff;
      end
   end

   // ---------------- stage 5: merge partial products ----------------
   logic signed [FW-1:0] pl_in [3], ph_in [3];
   logic signed [FW-1:0] pl_ff [3], ph_ff [3];
   logic                 small5_ff, edge5_ff, unit5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pl_in[k] = (FW'(plh_ff[k]) <<< LW) + FW'(pll_ff[k]);
         ph_in[k] = (FW'(phh_ff[k]) <<< LW) + FW'(phl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         small5_ff <= small4_ff;
         edge5_ff  <= edge4_ff;
         unit5_ff  <= unit4_ff;
      end
   end

   // ---------------- stage 6: normal axis test, response ----------------
   // box interval relative to v0 must straddle zero on the normal
   logic signed [FSW-1:0] slo, shi;
   logic                  hit_in, hit_ff;

   always_comb begin
      slo = FSW'(pl_ff[0]) + FSW'(pl_ff[1]) + FSW'(pl_ff[2]);
      shi = FSW'(ph_ff[0]) + FSW'(ph_ff[1]) + FSW'(ph_ff[2]);
      hit_in = unit5_ff && edge5_ff
            && (small5_ff || (!shi[FSW-1] && (slo[FSW-1] || slo == '0)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_ch.hit = hit_ff;

   `ATOT_ASSERT_NEXT(a_empty_stays_empty, clock, reset, (vld_ff == '0) && !take, !rsp_ch.valid)
   `ATOT_ASSERT_NEXT(a_first_stage_fills, clock, reset, take, vld_ff[0])
   `ATOT_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(vld_ff))
endmodule
`default_nettype wire
